/* design/mi_pkg.sv */
// ----------------------------------------------------------------------------
// mi_pkg
// Shared constants, request codes and the result record of the multiset
// intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package mi_pkg;

   localparam int MI_MAX_LEN = 32;
   localparam int MI_DATA_W  = 32;

   // request selector codes
   localparam logic [1:0] REQ_APPEND_A = 2'd0;
   localparam logic [1:0] REQ_APPEND_B = 2'd1;
   localparam logic [1:0] REQ_RUN      = 2'd2;

   typedef struct packed {
      logic signed [MI_DATA_W-1:0] match_value;
      logic                        is_last;
      logic                        none_found;
      logic                        overflowed;
   } result_type;

endpackage

`default_nettype wire

/* design/multiset_intersection.sv */
// ----------------------------------------------------------------------------
// multiset_intersection
// Bounded multiset intersection of two lists of signed 32-bit values.
// ----------------------------------------------------------------------------
// The request channel carries req_type and req_value. An append to A or B
// gives no response; a full list drops the value and sets a
// sticky overflow flag. A run walks list A in order and, for each element,
// scans list B for the first equal entry not yet used; a hit marks that entry
// used and yields a response carrying the A value. The single equality
// comparator handles one B entry per cycle while a stalled receiver does not
// hold the run, and a run scans at most count_a*count_b B entries in all.
// A run with no hit gives one response with none_found set and value zero.
// is_last marks the final response; overflowed repeats the flag on each one.
// After a run both lists, used marks and the overflow flag are empty again.
// req_stall stays high for the whole run. Responses pass through a pending
// slot and an output register; with both full, a stalled receiver holds the
// run at its next hit or at its end.
// Reset is synchronous: lists empty, no response pending, ready for requests.
// ----------------------------------------------------------------------------
`default_nettype none

module multiset_intersection
   import mi_pkg::*;
#(
   parameter int MAX_LEN = MI_MAX_LEN
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_type,
   input  wire logic signed [MI_DATA_W-1:0] req_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [MI_DATA_W-1:0]      rsp_match_value,
   output logic                             rsp_is_last,
   output logic                             rsp_none_found,
   output logic                             rsp_overflowed
);

   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   logic                 wr_a_en;
   logic                 wr_b_en;
   logic [IDX_W-1:0]     wr_a_addr;
   logic [IDX_W-1:0]     wr_b_addr;
   logic [MI_DATA_W-1:0] wr_data;
   logic [IDX_W-1:0]     rd_a_addr;
   logic [IDX_W-1:0]     rd_b_addr;
   logic [MI_DATA_W-1:0] a_data;
   logic [MI_DATA_W-1:0] b_data;
   result_type           rsp;

   mi_ram #(
      .DEPTH  (MAX_LEN),
      .ADDR_W (IDX_W),
      .DATA_W (MI_DATA_W)
   ) u_list_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (wr_a_addr),
      .wr_data (wr_data),
      .rd_addr (rd_a_addr),
      .rd_data (a_data)
   );

   mi_ram #(
      .DEPTH  (MAX_LEN),
      .ADDR_W (IDX_W),
      .DATA_W (MI_DATA_W)
   ) u_list_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (wr_b_addr),
      .wr_data (wr_data),
      .rd_addr (rd_b_addr),
      .rd_data (b_data)
   );

   mi_seq #(
      .MAX_LEN (MAX_LEN),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .wr_a_en   (wr_a_en),
      .wr_b_en   (wr_b_en),
      .wr_a_addr (wr_a_addr),
      .wr_b_addr (wr_b_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .a_data    (a_data),
      .b_data    (b_data)
   );

   assign rsp_match_value = rsp.match_value;
   assign rsp_is_last     = rsp.is_last;
   assign rsp_none_found  = rsp.none_found;
   assign rsp_overflowed  = rsp.overflowed;

endmodule

`default_nettype wire

/* design/mi_ram.sv */
// ----------------------------------------------------------------------------
// mi_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module mi_ram #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/mi_seq.sv */
// ----------------------------------------------------------------------------
// mi_seq
// Sequencer of the intersection: list counters, used marks, the shared
// equality compare, the pending result and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mi_seq
   import mi_pkg::*;
#(
   parameter int MAX_LEN = MI_MAX_LEN,
   parameter int IDX_W   = 5,
   parameter int CNT_W   = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_type,
   input  wire logic [MI_DATA_W-1:0] req_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output result_type                rsp,
   output logic                      wr_a_en,
   output logic                      wr_b_en,
   output logic [IDX_W-1:0]          wr_a_addr,
   output logic [IDX_W-1:0]          wr_b_addr,
   output logic [MI_DATA_W-1:0]      wr_data,
   output logic [IDX_W-1:0]          rd_a_addr,
   output logic [IDX_W-1:0]          rd_b_addr,
   input  wire logic [MI_DATA_W-1:0] a_data,
   input  wire logic [MI_DATA_W-1:0] b_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_LEN);

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_a_ff, count_a_in;
   logic [CNT_W-1:0]     count_b_ff, count_b_in;
   logic                 ovf_ff, ovf_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic [MAX_LEN-1:0]   used_ff, used_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [MI_DATA_W-1:0] pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff, rsp_in;

   logic                 req_xfer;
   logic                 out_free;
   logic                 hit;
   logic                 last_a;
   logic                 last_b;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hit       = !used_ff[j_ff[IDX_W-1:0]] && (a_data == b_data);
   assign last_a    = ((i_ff + 1'b1) == count_a_ff);
   assign last_b    = ((j_ff + 1'b1) == count_b_ff);

   always_comb begin
      state_in      = state_ff;
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      ovf_in        = ovf_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      used_in       = used_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      wr_a_en       = 1'b0;
      wr_b_en       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_type)
                  REQ_APPEND_A: begin
                     if (count_a_ff < FULL_COUNT) begin
                        wr_a_en    = 1'b1;
                        count_a_in = count_a_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  REQ_APPEND_B: begin
                     if (count_b_ff < FULL_COUNT) begin
                        wr_b_en    = 1'b1;
                        count_b_in = count_b_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  REQ_RUN: begin
                     i_in = '0;
                     j_in = '0;
                     if (count_a_ff == '0 || count_b_ff == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_RUN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (hit) begin
               // a new match can only go to the pending slot once the old one moves out
               if (!pend_valid_ff || out_free) begin
                  used_in[j_ff[IDX_W-1:0]] = 1'b1;
                  if (pend_valid_ff) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.match_value = pend_ff;
                     rsp_in.is_last     = 1'b0;
                     rsp_in.none_found  = 1'b0;
                     rsp_in.overflowed  = ovf_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = a_data;
                  j_in          = '0;
                  if (last_a) begin
                     state_in = ST_FINISH;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end
            end else if (last_b) begin
               j_in = '0;
               if (last_a) begin
                  state_in = ST_FINISH;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.is_last    = 1'b1;
               rsp_in.overflowed = ovf_ff;
               if (pend_valid_ff) begin
                  rsp_in.match_value = pend_ff;
                  rsp_in.none_found  = 1'b0;
               end else begin
                  rsp_in.match_value = '0;
                  rsp_in.none_found  = 1'b1;
               end
               pend_valid_in = 1'b0;
               count_a_in    = '0;
               count_b_in    = '0;
               ovf_in        = 1'b0;
               used_in       = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         ovf_ff        <= 1'b0;
         used_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         ovf_ff        <= ovf_in;
         used_ff       <= used_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // reads are issued with the next index so the data lines up with i_ff and j_ff
   assign rd_a_addr = i_in[IDX_W-1:0];
   assign rd_b_addr = j_in[IDX_W-1:0];
   assign wr_a_addr = count_a_ff[IDX_W-1:0];
   assign wr_b_addr = count_b_ff[IDX_W-1:0];
   assign wr_data   = req_value;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("pending result left over outside a run");

   a_finish_emits_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (rsp_valid_ff && rsp_ff.is_last))
      else $error("run finished without a final result");

   a_empty_is_last_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.none_found) |-> (rsp_ff.is_last && rsp_ff.match_value == '0))
      else $error("empty result not final or not zero");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (count_a_ff <= FULL_COUNT) && (count_b_ff <= FULL_COUNT))
      else $error("list count beyond capacity");

   a_run_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> (i_ff < count_a_ff) && (j_ff < count_b_ff))
      else $error("scan index outside loaded lists");

endmodule

`default_nettype wire
